/* design/wps_pkg.sv */
// Shared types and constants for the windowed percentile statistics unit.
`timescale 1ns / 1ps
package wps_pkg;

   localparam int DEF_NUM_SLOTS       = 16;
   localparam int DEF_WINDOW_DEPTH    = 256;
   localparam int DEF_MAX_PERCENTILES = 8;

   // Input operation codes.
   localparam logic FUNC_OBSERVE = 1'b0;
   localparam logic FUNC_REPORT  = 1'b1;

   // Register indexes, taken from paddr[4:3].
   localparam logic [1:0] REG_WIN_SIZE  = 2'd0;
   localparam logic [1:0] REG_PCT_COUNT = 2'd1;
   localparam logic [1:0] REG_PCT_LIST  = 2'd2;

   localparam logic [8:0]  RESET_WIN_SIZE  = 9'd256;
   localparam logic [3:0]  RESET_PCT_COUNT = 4'd1;
   localparam logic [63:0] RESET_PCT_LIST  = 64'd0;

   // Division by 100 as a multiply by a reciprocal plus one correction step.
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int PCT_SCALE   = 100;

   typedef struct packed {
      logic        func;
      logic [3:0]  key_slot;
      logic [62:0] value;
   } item_type;

   typedef struct packed {
      logic [3:0]  slot_out;
      logic [7:0]  rank;
      logic [62:0] rank_value;
      logic [63:0] win_count;
      logic [63:0] win_sum;
      logic [62:0] win_min;
      logic [62:0] win_max;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [8:0]  win_size;
      logic [3:0]  percentile_count;
      logic [63:0] percentile_list;
   } cfg_type;

endpackage

/* design/wps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* design/wps_fifo.sv */
// Small register-based FIFO used for the word queues.
`timescale 1ns / 1ps
module wps_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);
   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] buf_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]      count_ff;
   logic             do_wr, do_rd;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = buf_ff[rd_ptr_ff];

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         buf_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // Pointers wrap at the depth.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end
endmodule

/* design/wps_front.sv */
// Front end: accepts input words, drops out-of-range slots and queues the rest.
`timescale 1ns / 1ps
module wps_front #(
   parameter int NUM_SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  wps_pkg::item_type req_item,
   input  logic              item_pop,
   output wps_pkg::item_type item_head,
   output logic              item_empty
);
   import wps_pkg::*;

   logic in_range;
   logic queue_wr;

   // A slot beyond the tracked set is accepted and then ignored.
   assign in_range = ({5'd0, req_item.key_slot} < 9'(NUM_SLOTS));
   assign queue_wr = req_push && !req_full && in_range;

   wps_fifo #(
      .WIDTH ($bits(item_type)),
      .DEPTH (4)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (queue_wr),
      .wr_data (req_item),
      .full    (req_full),
      .rd_en   (item_pop),
      .rd_data (item_head),
      .empty   (item_empty)
   );
endmodule

/* design/wps_back.sv */
// Back end: applies observe words to the ring and slot statistics, runs reports.
`timescale 1ns / 1ps
module wps_back #(
   parameter int NUM_SLOTS       = 16,
   parameter int WINDOW_DEPTH    = 256,
   parameter int MAX_PERCENTILES = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  wps_pkg::cfg_type    cfg,
   input  wps_pkg::item_type   item_head,
   input  logic                item_empty,
   output logic                item_pop,
   input  logic                out_full,
   output logic                out_push,
   output wps_pkg::result_type out_result
);
   import wps_pkg::*;

   localparam int WS_W   = $clog2(WINDOW_DEPTH + 1);
   localparam int IDX_W  = $clog2(WINDOW_DEPTH);
   localparam int ADDR_W = $clog2(NUM_SLOTS * WINDOW_DEPTH);
   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int PK_W   = (MAX_PERCENTILES > 1) ? $clog2(MAX_PERCENTILES) : 1;
   localparam int X_W    = 8 + WS_W;
   localparam int Q_W    = X_W + 13;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SETUP, ST_MUL1, ST_MUL2, ST_COR,
      ST_CRD, ST_CLAT, ST_SCAN, ST_EVAL, ST_EMIT
   } state_type;

   state_type state_ff;

   // Per-slot state.
   logic [IDX_W-1:0] wpos_ff    [NUM_SLOTS];
   logic [WS_W-1:0]  fresh_ff   [NUM_SLOTS];
   logic [63:0]      scount_ff  [NUM_SLOTS];
   logic [63:0]      ssum_ff    [NUM_SLOTS];
   logic [62:0]      smin_ff    [NUM_SLOTS];
   logic [62:0]      smax_ff    [NUM_SLOTS];
   logic             restart_ff [NUM_SLOTS];

   // Report working registers.
   logic [SLOT_W-1:0] slot_ff;
   logic [3:0]        key_ff;
   logic [WS_W-1:0]   n_ff;
   logic [IDX_W-1:0]  base_ff;
   logic [3:0]        pk_ff;
   logic [X_W-1:0]    x_ff;
   logic [X_W-1:0]    q_ff;
   logic [WS_W-1:0]   tgt_ff  [MAX_PERCENTILES];
   logic [62:0]       ans_ff  [MAX_PERCENTILES];
   logic [WS_W-1:0]   cand_k_ff;
   logic [IDX_W-1:0]  cand_idx_ff;
   logic [62:0]       cand_ff;
   logic [WS_W-1:0]   scan_k_ff;
   logic [IDX_W-1:0]  scan_idx_ff;
   logic              pend_ff;
   logic [WS_W-1:0]   lt_ff, le_ff;

   logic [12:0]       ws_raw;
   logic [WS_W-1:0]   ws;
   logic [3:0]        pc;
   logic [SLOT_W-1:0] in_slot;
   logic [IDX_W-1:0]  cur_wp, cur_pos, pos_in;
   logic [WS_W-1:0]   cur_fresh, n_in;
   logic [WS_W:0]     base_sum;
   logic [IDX_W-1:0]  base_in;
   logic [7:0]        pct;
   logic [Q_W-1:0]    q_prod;
   logic [X_W-1:0]    q_fix;
   logic [WS_W-1:0]   tgt_in;
   logic [62:0]       obs_min_in, obs_max_in;
   logic [63:0]       obs_cnt_in, obs_sum_in;
   logic              obs_go;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [IDX_W-1:0]  rd_idx;
   logic [62:0]       rd_data;
   logic [SLOT_W-1:0] sel_slot;

   // Wrap-around increment of a ring index.
   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i,
                                                  input logic [WS_W-1:0] size);
      logic [WS_W-1:0] nxt;
      nxt = WS_W'(i) + 1'b1;
      return (nxt >= size) ? '0 : nxt[IDX_W-1:0];
   endfunction

   // Effective register values after clamping.
   assign ws_raw = {4'd0, cfg.win_size};
   assign ws = (ws_raw == 13'd0) ? WS_W'(1) :
               (ws_raw > 13'(WINDOW_DEPTH)) ? WS_W'(WINDOW_DEPTH) : WS_W'(ws_raw);
   assign pc = (cfg.percentile_count == 4'd0) ? 4'd1 :
               (cfg.percentile_count > 4'(MAX_PERCENTILES)) ? 4'(MAX_PERCENTILES) :
               cfg.percentile_count;

   // Slot selection: the queue head while idle, the latched slot otherwise.
   assign in_slot  = SLOT_W'(item_head.key_slot);
   assign sel_slot = (state_ff == ST_IDLE) ? in_slot : slot_ff;

   assign cur_wp    = wpos_ff[sel_slot];
   assign cur_fresh = fresh_ff[sel_slot];
   assign cur_pos   = (WS_W'(cur_wp) >= ws) ? '0 : cur_wp;
   assign pos_in    = ring_next(cur_pos, ws);
   assign n_in      = (cur_fresh > ws) ? ws : cur_fresh;
   assign base_sum  = (WS_W+1)'(cur_pos) + (WS_W+1)'(ws) - (WS_W+1)'(n_in);
   assign base_in   = (base_sum >= (WS_W+1)'(ws)) ?
                      IDX_W'(base_sum - (WS_W+1)'(ws)) : IDX_W'(base_sum);

   // Observe statistics, restarting the statistics when flagged.
   always_comb begin
      if (restart_ff[in_slot]) begin
         obs_cnt_in = 64'd1;
         obs_sum_in = {1'b0, item_head.value};
         obs_min_in = item_head.value;
         obs_max_in = item_head.value;
      end else begin
         obs_cnt_in = scount_ff[in_slot] + 64'd1;
         obs_sum_in = ssum_ff[in_slot] + {1'b0, item_head.value};
         obs_min_in = (item_head.value < smin_ff[in_slot]) ? item_head.value
                                                           : smin_ff[in_slot];
         obs_max_in = (item_head.value > smax_ff[in_slot]) ? item_head.value
                                                           : smax_ff[in_slot];
      end
   end

   assign obs_go   = (state_ff == ST_IDLE) && !item_empty &&
                     (item_head.func == FUNC_OBSERVE);
   assign item_pop = (state_ff == ST_IDLE) && !item_empty;
   assign wr_en    = obs_go;
   assign wr_addr  = ADDR_W'(in_slot) * ADDR_W'(WINDOW_DEPTH) + ADDR_W'(cur_pos);
   assign rd_idx   = (state_ff == ST_CRD) ? cand_idx_ff : scan_idx_ff;
   assign rd_addr  = ADDR_W'(slot_ff) * ADDR_W'(WINDOW_DEPTH) + ADDR_W'(rd_idx);

   // Percentile index: floor(p*n/100) by reciprocal, then one correction, minus one and clamped to 0..n-1.
   assign pct    = cfg.percentile_list[8*pk_ff[2:0] +: 8];
   assign q_prod = Q_W'(x_ff) * Q_W'(RECIP_100);
   assign q_fix  = ((Q_W'(q_ff) * Q_W'(PCT_SCALE)) > Q_W'(x_ff)) ? q_ff - 1'b1 : q_ff;
   always_comb begin
      if (q_fix == '0) begin
         tgt_in = '0;
      end else if ((q_fix - 1'b1) > X_W'(n_ff - 1'b1)) begin
         tgt_in = n_ff - 1'b1;
      end else begin
         tgt_in = WS_W'(q_fix - 1'b1);
      end
   end

   wps_ram #(
      .WIDTH (63),
      .DEPTH (NUM_SLOTS * WINDOW_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (item_head.value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Result word for the current percentile.
   assign out_push             = (state_ff == ST_EMIT) && !out_full;
   assign out_result.slot_out   = key_ff;
   assign out_result.rank       = pct;
   assign out_result.rank_value = ans_ff[pk_ff[PK_W-1:0]];
   assign out_result.win_count  = scount_ff[slot_ff];
   assign out_result.win_sum    = ssum_ff[slot_ff];
   assign out_result.win_min    = smin_ff[slot_ff];
   assign out_result.win_max    = smax_ff[slot_ff];
   assign out_result.last       = (pk_ff == pc - 4'd1);

   // Statistics registers need no reset: no report reads them before an observe.
   always_ff @(posedge clock) begin
      if (obs_go) begin
         scount_ff[in_slot] <= obs_cnt_in;
         ssum_ff[in_slot]   <= obs_sum_in;
         smin_ff[in_slot]   <= obs_min_in;
         smax_ff[in_slot]   <= obs_max_in;
      end
   end

   // Sequencer and per-slot control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         for (int s = 0; s < NUM_SLOTS; s++) begin
            wpos_ff[s]    <= '0;
            fresh_ff[s]   <= '0;
            restart_ff[s] <= 1'b1;
         end
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (obs_go) begin
                  wpos_ff[in_slot]    <= pos_in;
                  fresh_ff[in_slot]   <= (cur_fresh < ws) ? cur_fresh + 1'b1 : ws;
                  restart_ff[in_slot] <= 1'b0;
               end else if (!item_empty) begin
                  slot_ff  <= in_slot;
                  key_ff   <= item_head.key_slot;
                  state_ff <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               n_ff    <= n_in;
               base_ff <= base_in;
               pk_ff   <= 4'd0;
               state_ff <= (n_in == '0) ? ST_IDLE : ST_MUL1;
            end
            ST_MUL1: begin
               x_ff     <= X_W'(pct) * X_W'(n_ff);
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               q_ff     <= X_W'(q_prod >> RECIP_SHIFT);
               state_ff <= ST_COR;
            end
            ST_COR: begin
               tgt_ff[pk_ff[PK_W-1:0]] <= tgt_in;
               if (pk_ff == pc - 4'd1) begin
                  cand_k_ff   <= '0;
                  cand_idx_ff <= base_ff;
                  state_ff    <= ST_CRD;
               end else begin
                  pk_ff    <= pk_ff + 4'd1;
                  state_ff <= ST_MUL1;
               end
            end
            ST_CRD: begin
               state_ff <= ST_CLAT;
            end
            ST_CLAT: begin
               cand_ff     <= rd_data;
               lt_ff       <= '0;
               le_ff       <= '0;
               scan_k_ff   <= '0;
               scan_idx_ff <= base_ff;
               state_ff    <= ST_SCAN;
            end
            ST_SCAN: begin
               // One window entry read per cycle, compared when its data returns.
               if (scan_k_ff < n_ff) begin
                  scan_k_ff   <= scan_k_ff + 1'b1;
                  scan_idx_ff <= ring_next(scan_idx_ff, ws);
                  pend_ff     <= 1'b1;
               end else begin
                  pend_ff <= 1'b0;
               end
               if (pend_ff) begin
                  if (rd_data < cand_ff) begin
                     lt_ff <= lt_ff + 1'b1;
                     le_ff <= le_ff + 1'b1;
                  end else if (rd_data == cand_ff) begin
                     le_ff <= le_ff + 1'b1;
                  end
               end
               if (scan_k_ff == n_ff && !pend_ff) begin
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               // The candidate fills sorted positions lt up to le-1.
               for (int k = 0; k < MAX_PERCENTILES; k++) begin
                  if (lt_ff <= tgt_ff[k] && tgt_ff[k] < le_ff) begin
                     ans_ff[k] <= cand_ff;
                  end
               end
               if (cand_k_ff + 1'b1 == n_ff) begin
                  pk_ff    <= 4'd0;
                  state_ff <= ST_EMIT;
               end else begin
                  cand_k_ff   <= cand_k_ff + 1'b1;
                  cand_idx_ff <= ring_next(cand_idx_ff, ws);
                  state_ff    <= ST_CRD;
               end
            end
            ST_EMIT: begin
               if (!out_full) begin
                  if (pk_ff == pc - 4'd1) begin
                     fresh_ff[slot_ff]   <= '0;
                     restart_ff[slot_ff] <= 1'b1;
                     state_ff            <= ST_IDLE;
                  end else begin
                     pk_ff <= pk_ff + 4'd1;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end
endmodule

/* design/windowed_percentile_stats_unit.sv */
// Top level of the windowed percentile statistics unit.
`timescale 1ns / 1ps
// Each key slot keeps a ring of its most recent observed values, as many as the configured
// window size, plus a running count, sum, min and max since its last report. Observe words
// are queued by the front end and retire at one per cycle while no report is running, set by
// the single ring write port. A report with n fresh values first works out a target rank for
// each of its P percentiles; each of the n candidates is then ranked by a pass over the n
// fresh values through the one ring read port, so the rank search dominates. Reports with
// nothing fresh emit no word. Words wait in a two-entry result queue; once it is full the
// back end holds in its emit step until the consumer takes a word.
module windowed_percentile_stats_unit #(
   parameter int NUM_SLOTS       = wps_pkg::DEF_NUM_SLOTS,
   parameter int WINDOW_DEPTH    = wps_pkg::DEF_WINDOW_DEPTH,
   parameter int MAX_PERCENTILES = wps_pkg::DEF_MAX_PERCENTILES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_func,
   input  logic [3:0]  req_key_slot,
   input  logic [62:0] req_value,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [3:0]  rsp_slot_out,
   output logic [7:0]  rsp_rank,
   output logic [62:0] rsp_rank_value,
   output logic [63:0] rsp_win_count,
   output logic [63:0] rsp_win_sum,
   output logic [62:0] rsp_win_min,
   output logic [62:0] rsp_win_max,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import wps_pkg::*;

   cfg_type    cfg_ff;
   item_type   req_item, item_head;
   logic       item_empty, item_pop;
   logic       out_full, out_push;
   result_type out_result, rsp_word;
   logic       csr_wr;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.win_size         <= RESET_WIN_SIZE;
         cfg_ff.percentile_count <= RESET_PCT_COUNT;
         cfg_ff.percentile_list  <= RESET_PCT_LIST;
      end else if (csr_wr) begin
         case (csr_paddr[4:3])
            REG_WIN_SIZE:  cfg_ff.win_size         <= csr_pwdata[8:0];
            REG_PCT_COUNT: cfg_ff.percentile_count <= csr_pwdata[3:0];
            REG_PCT_LIST:  cfg_ff.percentile_list  <= csr_pwdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:3])
         REG_WIN_SIZE:  csr_prdata = {55'd0, cfg_ff.win_size};
         REG_PCT_COUNT: csr_prdata = {60'd0, cfg_ff.percentile_count};
         REG_PCT_LIST:  csr_prdata = cfg_ff.percentile_list;
         default:       csr_prdata = 64'd0;
      endcase
   end

   assign req_item.func     = req_func;
   assign req_item.key_slot = req_key_slot;
   assign req_item.value    = req_value;

   wps_front #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_item   (req_item),
      .item_pop   (item_pop),
      .item_head  (item_head),
      .item_empty (item_empty)
   );

   wps_back #(
      .NUM_SLOTS       (NUM_SLOTS),
      .WINDOW_DEPTH    (WINDOW_DEPTH),
      .MAX_PERCENTILES (MAX_PERCENTILES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_head  (item_head),
      .item_empty (item_empty),
      .item_pop   (item_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_result (out_result)
   );

   // Result queue toward the consumer.
   wps_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (2)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (out_push),
      .wr_data (out_result),
      .full    (out_full),
      .rd_en   (rsp_pop),
      .rd_data (rsp_word),
      .empty   (rsp_empty)
   );

   assign rsp_slot_out   = rsp_word.slot_out;
   assign rsp_rank       = rsp_word.rank;
   assign rsp_rank_value = rsp_word.rank_value;
   assign rsp_win_count  = rsp_word.win_count;
   assign rsp_win_sum    = rsp_word.win_sum;
   assign rsp_win_min    = rsp_word.win_min;
   assign rsp_win_max    = rsp_word.win_max;
   assign rsp_last       = rsp_word.last;
endmodule

/* tb/sv/wps_checker.sv */
// Checker for the windowed percentile statistics unit: predicts and compares result words.
`timescale 1ns / 1ps
module wps_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic        req_func,
   input  logic [3:0]  req_key_slot,
   input  logic [62:0] req_value,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [3:0]  rsp_slot_out,
   input  logic [7:0]  rsp_rank,
   input  logic [62:0] rsp_rank_value,
   input  logic [63:0] rsp_win_count,
   input  logic [63:0] rsp_win_sum,
   input  logic [62:0] rsp_win_min,
   input  logic [62:0] rsp_win_max,
   input  logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending_words
);
   import wps_pkg::*;

   // Shadow copy of the per-slot state and of the registers.
   bit [62:0]  ring_vals [DEF_NUM_SLOTS][DEF_WINDOW_DEPTH];
   bit [7:0]   wr_pos [DEF_NUM_SLOTS];
   bit [8:0]   fresh_vals [DEF_NUM_SLOTS];
   bit [63:0]  obs_count [DEF_NUM_SLOTS];
   bit [63:0]  obs_sum [DEF_NUM_SLOTS];
   bit [62:0]  obs_min [DEF_NUM_SLOTS];
   bit [62:0]  obs_max [DEF_NUM_SLOTS];
   bit         needs_restart [DEF_NUM_SLOTS];
   cfg_type    cfg;
   result_type expected_words [$];

   function automatic int unsigned window_len();
      if (cfg.win_size == 0) return 1;
      if (cfg.win_size > DEF_WINDOW_DEPTH) return DEF_WINDOW_DEPTH;
      return cfg.win_size;
   endfunction

   function automatic int unsigned pct_len();
      if (cfg.percentile_count == 0) return 1;
      if (cfg.percentile_count > DEF_MAX_PERCENTILES) return DEF_MAX_PERCENTILES;
      return cfg.percentile_count;
   endfunction

   // Append a value to the slot's ring and fold it into the window statistics.
   task automatic observe_value(int unsigned s, bit [62:0] v);
      int unsigned ws;
      int unsigned pos;
      ws = window_len();
      pos = wr_pos[s];
      if (pos >= ws) pos = 0;
      ring_vals[s][pos] = v;
      pos++;
      if (pos >= ws) pos = 0;
      wr_pos[s] = pos[7:0];
      if (fresh_vals[s] < ws) fresh_vals[s]++;
      else fresh_vals[s] = ws[8:0];
      if (needs_restart[s]) begin
         obs_count[s] = 0;
         obs_sum[s] = 0;
         obs_min[s] = v;
         obs_max[s] = v;
         needs_restart[s] = 1'b0;
      end
      obs_count[s] += 1;
      obs_sum[s] += {1'b0, v};
      if (v < obs_min[s]) obs_min[s] = v;
      if (v > obs_max[s]) obs_max[s] = v;
   endtask

   // Sort the fresh values and queue one word per configured percentile.
   task automatic report_slot(int unsigned s);
      int unsigned ws, pos, n, idx, q, p, pc;
      bit [62:0] sorted_vals [$];
      result_type r;
      ws = window_len();
      pos = wr_pos[s];
      if (pos >= ws) pos = 0;
      n = fresh_vals[s];
      if (n > ws) n = ws;
      if (n == 0) return;
      for (int unsigned k = 0; k < n; k++) begin
         idx = (pos + ws - n + k) % ws;
         sorted_vals.push_back(ring_vals[s][idx]);
      end
      sorted_vals.sort();
      pc = pct_len();
      for (int unsigned k = 0; k < pc; k++) begin
         p = cfg.percentile_list[8*k +: 8];
         q = (p * n) / 100;
         idx = (q == 0) ? 0 : q - 1;
         if (idx > n - 1) idx = n - 1;
         r.slot_out = s[3:0];
         r.rank = p[7:0];
         r.rank_value = sorted_vals[idx];
         r.win_count = obs_count[s];
         r.win_sum = obs_sum[s];
         r.win_min = obs_min[s];
         r.win_max = obs_max[s];
         r.last = (k + 1 == pc);
         expected_words.push_back(r);
      end
      fresh_vals[s] = 0;
      needs_restart[s] = 1'b1;
   endtask

   function automatic void check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0h, got %0h", name, exp_val, act_val);
         fail_count++;
      end
   endfunction

   initial fail_count = 0;

   always @(posedge clock) begin
      result_type e;
      if (reset) begin
         cfg.win_size = RESET_WIN_SIZE;
         cfg.percentile_count = RESET_PCT_COUNT;
         cfg.percentile_list = RESET_PCT_LIST;
         for (int s = 0; s < DEF_NUM_SLOTS; s++) begin
            wr_pos[s] = 0;
            fresh_vals[s] = 0;
            obs_count[s] = 0;
            obs_sum[s] = 0;
            obs_min[s] = 0;
            obs_max[s] = 0;
            needs_restart[s] = 1'b1;
         end
         expected_words.delete();
      end else begin
         // Register writes.
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:3])
               REG_WIN_SIZE:  cfg.win_size = csr_pwdata[8:0];
               REG_PCT_COUNT: cfg.percentile_count = csr_pwdata[3:0];
               REG_PCT_LIST:  cfg.percentile_list = csr_pwdata;
               default: ;
            endcase
         end
         // Accepted result word against the oldest expectation.
         if (rsp_pop && !rsp_empty) begin
            if (expected_words.size() == 0) begin
               $error("result word with no expectation waiting");
               fail_count++;
            end else begin
               e = expected_words.pop_front();
               check_field("slot_out", e.slot_out, rsp_slot_out);
               check_field("rank", e.rank, rsp_rank);
               check_field("rank_value", e.rank_value, rsp_rank_value);
               check_field("win_count", e.win_count, rsp_win_count);
               check_field("win_sum", e.win_sum, rsp_win_sum);
               check_field("win_min", e.win_min, rsp_win_min);
               check_field("win_max", e.win_max, rsp_win_max);
               check_field("last", e.last, rsp_last);
            end
         end
         // Accepted input word.
         if (req_push && !req_full) begin
            if (req_func == FUNC_OBSERVE) observe_value(req_key_slot, req_value);
            else report_slot(req_key_slot);
         end
      end
      pending_words = expected_words.size();
   end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top for the windowed percentile statistics unit: stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
   import wps_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int SETTLE_CYCLES = 600;
   localparam logic [62:0] VALUE_MAX = {63{1'b1}};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_func = FUNC_OBSERVE;
   logic [3:0]  req_key_slot = '0;
   logic [62:0] req_value = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [3:0]  rsp_slot_out;
   logic [7:0]  rsp_rank;
   logic [62:0] rsp_rank_value;
   logic [63:0] rsp_win_count;
   logic [63:0] rsp_win_sum;
   logic [62:0] rsp_win_min;
   logic [62:0] rsp_win_max;
   logic        rsp_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          pending_words;
   int          send_idle_pct = 24;
   int          recv_idle_pct = 55;
   bit          hold_request = 1'b0;
   int          cycle_count = 0;

   always #4 clock = ~clock;

   windowed_percentile_stats_unit u_dut (.*);

   wps_checker u_checker (.*);

   // Timeout guard.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("windowed_percentile_stats_unit: mismatch");
         $finish;
      end
   end

   // Receiver: random pops, with a long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 3000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Offer one word and hold it until it is accepted; returns at a falling edge.
   task automatic send_word(logic func, logic [3:0] slot, logic [62:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_func <= func;
      req_key_slot <= slot;
      req_value <= v;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   task automatic wait_results();
      req_push <= 1'b0;
      @(negedge clock);
      while (pending_words != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [63:0] data);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Report every slot so no stale window survives a size change, then write.
   task automatic reconfigure(logic [8:0] ws, logic [3:0] pc, logic [63:0] pct_list);
      for (int s = 0; s < DEF_NUM_SLOTS; s++) send_word(FUNC_REPORT, s[3:0], '0);
      wait_results();
      csr_write(REG_WIN_SIZE, {55'd0, ws});
      csr_write(REG_PCT_COUNT, {60'd0, pc});
      csr_write(REG_PCT_LIST, pct_list);
   endtask

   function automatic logic [62:0] pick_value();
      case ($urandom_range(9))
         0: return '0;
         1: return VALUE_MAX;
         2, 3, 4: return 63'($urandom_range(20));
         default: return 63'({$urandom, $urandom});
      endcase
   endfunction

   function automatic logic [63:0] random_pct_list();
      logic [63:0] l;
      for (int k = 0; k < 8; k++)
         l[8*k +: 8] = ($urandom_range(5) == 0) ? 8'($urandom_range(255))
                                                 : 8'($urandom_range(100));
      return l;
   endfunction

   // Mostly observe runs on a few slots, closed by reports.
   task automatic random_words(int count, int report_pct);
      int base;
      base = $urandom_range(12);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < report_pct)
            send_word(FUNC_REPORT, 4'(base + $urandom_range(3)),
                      63'({$urandom, $urandom}));
         else
            send_word(FUNC_OBSERVE, 4'(base + $urandom_range(3)), pick_value());
      end
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty report, reset settings, then wrap and odd percentiles.
      send_word(FUNC_REPORT, 4'd0, '0);
      send_word(FUNC_OBSERVE, 4'd0, VALUE_MAX);
      send_word(FUNC_OBSERVE, 4'd0, '0);
      send_word(FUNC_REPORT, 4'd0, '0);
      send_word(FUNC_REPORT, 4'd0, '0);
      reconfigure(9'd3, 4'd8, {8'd255, 8'd100, 8'd101, 8'd50, 8'd1, 8'd0, 8'd99, 8'd33});
      for (int i = 0; i < 5; i++) send_word(FUNC_OBSERVE, 4'd15, VALUE_MAX - i);
      send_word(FUNC_REPORT, 4'd15, VALUE_MAX);
      send_word(FUNC_REPORT, 4'd15, '0);
      send_word(FUNC_OBSERVE, 4'd15, 63'd7);
      send_word(FUNC_REPORT, 4'd15, '0);
      reconfigure(9'd0, 4'd0, 64'hFFFF_FFFF_FFFF_FF64);
      send_word(FUNC_OBSERVE, 4'd7, 63'd9);
      send_word(FUNC_OBSERVE, 4'd7, 63'd2);
      send_word(FUNC_REPORT, 4'd7, '0);
      reconfigure(9'd511, 4'd15, random_pct_list());
      send_word(FUNC_OBSERVE, 4'd1, 63'd5);
      send_word(FUNC_REPORT, 4'd1, '0);

      // Sender busy, receiver mostly stalled.
      send_idle_pct = 24;
      recv_idle_pct = 55;
      reconfigure(9'd8, 4'd8, random_pct_list());
      random_words(44, 15);

      // Receiver busy, sender mostly idle.
      send_idle_pct = 55;
      recv_idle_pct = 24;
      reconfigure(9'd16, 4'd3, random_pct_list());
      random_words(44, 12);

      // No idling: long receiver hold-off so the block backs up.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      reconfigure(9'd4, 4'd8, random_pct_list());
      hold_request = 1'b1;
      random_words(44, 40);
      reconfigure(9'd1, 4'd2, random_pct_list());
      random_words(20, 20);

      // A longer run of observes at the deepest window size.
      reconfigure(9'd256, 4'd8, random_pct_list());
      for (int i = 0; i < 30; i++) send_word(FUNC_OBSERVE, 4'd9, pick_value());
      send_word(FUNC_REPORT, 4'd9, '0);

      wait_results();
      if (fail_count == 0 && pending_words == 0)
         $display("windowed_percentile_stats_unit: match");
      else
         $display("windowed_percentile_stats_unit: mismatch");
      $finish;
   end

endmodule
